>>> rtl/core/csvg_pkg.sv
// csvg_pkg: shared types, constants and face table for the cube strip vertex generator
// no dependencies
`default_nettype none

package csvg_pkg;

  localparam int unsigned MAX_SUBDIV = 64;
  localparam int unsigned HALF_SIDE  = 8192;
  localparam int unsigned ONE_Q      = 16384;
  localparam int unsigned LAST_FACE  = 5;

  // configuration register indexes
  localparam logic CFG_SUBDIV = 1'b0;
  localparam logic CFG_STEP   = 1'b1;

  typedef enum logic [4:0] {
    PH_LEAD   = 5'b00001,
    PH_TOP    = 5'b00010,
    PH_BOTTOM = 5'b00100,
    PH_COLS   = 5'b01000,
    PH_TRAIL  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [2:0]       corner_neg;
    logic signed [1:0] norm_x;
    logic signed [1:0] norm_y;
    logic signed [1:0] norm_z;
    logic [1:0]       vaxis;
    logic [1:0]       haxis;
    logic             vneg;
    logic             hneg;
  } face_desc_t;

  // corner_neg bit i set means corner coordinate i is -1
  function automatic face_desc_t face_lookup(input logic [2:0] face);
    face_desc_t d;
    begin
      d = '0;
      case (face)
        3'd0: d = '{3'b101, -2'sd1, 2'sd0, 2'sd0, 2'd1, 2'd2, 1'b1, 1'b0};
        3'd1: d = '{3'b000, 2'sd1, 2'sd0, 2'sd0, 2'd1, 2'd2, 1'b1, 1'b1};
        3'd2: d = '{3'b011, 2'sd0, -2'sd1, 2'sd0, 2'd2, 2'd0, 1'b1, 1'b0};
        3'd3: d = '{3'b101, 2'sd0, 2'sd1, 2'sd0, 2'd2, 2'd0, 1'b0, 1'b0};
        3'd4: d = '{3'b100, 2'sd0, 2'sd0, -2'sd1, 2'd1, 2'd0, 1'b1, 1'b1};
        default: d = '{3'b001, 2'sd0, 2'sd0, 2'sd1, 2'd1, 2'd0, 1'b1, 1'b0};
      endcase
      return d;
    end
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/cube_strip_vertex_generator_top.sv
// cube_strip_vertex_generator_top: emits one cube triangle strip vertex per item
// depends on csvg_pkg
// the vertex of an accepted item is computed combinationally and registered in the output register
// throughput: one item per cycle; the output register takes a new vertex in the
// cycle its previous one is taken, so only out_stall holds off the input
// reset: counters return to the first vertex of the mesh, subdivisions to 1,
// cell step to 16384, output empty; config is always ready
`default_nettype none

module cube_strip_vertex_generator_top
  import csvg_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               in_restart,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic signed [15:0]      out_pos_x,
  output logic signed [15:0]      out_pos_y,
  output logic signed [15:0]      out_pos_z,
  output logic signed [1:0]       out_norm_x,
  output logic signed [1:0]       out_norm_y,
  output logic signed [1:0]       out_norm_z,
  output logic signed [15:0]      out_tex_u,
  output logic [14:0]             out_tex_v,
  output logic                    out_mesh_end,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic               cfg_index,
  input  wire logic [14:0]        cfg_data
);

  localparam logic signed [25:0] SAT_HI = 26'(ONE_Q);
  localparam logic signed [25:0] SAT_LO = -26'(ONE_Q);
  localparam logic signed [25:0] HS     = 26'(HALF_SIDE);

  // config registers
  logic [6:0]  subdiv_r;
  logic [14:0] step_r;
  logic [6:0]  subdiv_wr;

  // sequencer state
  logic [2:0]  face_r,  face_nxt;
  logic [6:0]  row_r,   row_nxt;
  logic [6:0]  col_r,   col_nxt;
  phase_t      phase_r, phase_nxt;
  logic        lower_r, lower_nxt;
  logic        started_r, started_nxt;

  // effective state after restart
  logic [2:0]  f0;
  logic [6:0]  r0, c0;
  phase_t      ph0;
  logic        l0, s0;

  face_desc_t  fd;
  logic        accept;
  logic        vbump, row_last, col_last;
  logic [7:0]  vofs, hofs;
  logic [22:0] vprod, hprod, vtex;
  logic signed [25:0] vterm, hterm, pos_s [3];
  logic signed [25:0] u_s;

  logic signed [15:0] pos_x_nxt, pos_y_nxt, pos_z_nxt, tex_u_nxt;
  logic [14:0] tex_v_nxt;
  logic        mesh_end_nxt;

  logic        out_valid_r;
  logic signed [15:0] pos_x_r, pos_y_r, pos_z_r, tex_u_r;
  logic signed [1:0]  norm_x_r, norm_y_r, norm_z_r;
  logic [14:0] tex_v_r;
  logic        mesh_end_r;

  function automatic logic signed [15:0] sat16(input logic signed [25:0] s);
    logic signed [15:0] res;
    begin
      if (s > SAT_HI) res = 16'(ONE_Q);
      else if (s < SAT_LO) res = -16'(ONE_Q);
      else res = s[15:0];
      return res;
    end
  endfunction

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r & out_stall;
  assign accept    = in_valid & ~in_stall;

  // clamp of subdivisions writes
  always_comb begin
    if (cfg_data[6:0] == 7'd0) subdiv_wr = 7'd1;
    else if (cfg_data[6:0] > 7'(MAX_SUBDIV)) subdiv_wr = 7'(MAX_SUBDIV);
    else subdiv_wr = cfg_data[6:0];
  end

  // effective state and vertex datapath
  always_comb begin
    f0  = in_restart ? 3'd0 : face_r;
    r0  = in_restart ? 7'd0 : row_r;
    c0  = in_restart ? 7'd0 : col_r;
    l0  = in_restart ? 1'b0 : lower_r;
    s0  = in_restart ? 1'b0 : started_r;
    ph0 = in_restart ? PH_LEAD : phase_r;
    if (f0 > 3'(LAST_FACE)) f0 = 3'd0;
    if (ph0 == PH_LEAD && !s0) ph0 = PH_TOP;

    fd = face_lookup(f0);

    vbump = (ph0 == PH_BOTTOM) || (ph0 == PH_COLS && l0) || (ph0 == PH_TRAIL);
    vofs  = {1'b0, r0} + {7'd0, vbump};
    if (ph0 == PH_COLS) hofs = {1'b0, c0} + 8'd1;
    else if (ph0 == PH_TRAIL) hofs = {1'b0, subdiv_r};
    else hofs = 8'd0;

    vprod = 23'(vofs) * 23'(step_r);
    hprod = 23'(hofs) * 23'(step_r);

    vterm = fd.vneg ? -$signed({3'b000, vprod}) : $signed({3'b000, vprod});
    hterm = fd.hneg ? -$signed({3'b000, hprod}) : $signed({3'b000, hprod});

    for (int i = 0; i < 3; i++) begin
      pos_s[i] = fd.corner_neg[i] ? -HS : HS;
      if (fd.vaxis == 2'(i)) pos_s[i] = pos_s[i] + vterm;
      if (fd.haxis == 2'(i)) pos_s[i] = pos_s[i] + hterm;
    end

    if (ph0 == PH_COLS) u_s = hterm;
    else if (ph0 == PH_TRAIL) u_s = SAT_HI;
    else u_s = '0;

    vtex = (ph0 == PH_TRAIL) ? vprod - {8'd0, step_r} : vprod;

    pos_x_nxt = sat16(pos_s[0]);
    pos_y_nxt = sat16(pos_s[1]);
    pos_z_nxt = sat16(pos_s[2]);
    tex_u_nxt = sat16(u_s);
    tex_v_nxt = (vtex > 23'(ONE_Q)) ? 15'(ONE_Q) : vtex[14:0];

    row_last     = ({1'b0, r0} + 8'd1) >= {1'b0, subdiv_r};
    col_last     = ({1'b0, c0} + 8'd1) >= {1'b0, subdiv_r};
    mesh_end_nxt = (ph0 == PH_TRAIL) && row_last && (f0 == 3'(LAST_FACE));
  end

  // sequencer next state
  always_comb begin
    face_nxt    = f0;
    row_nxt     = r0;
    col_nxt     = c0;
    lower_nxt   = l0;
    started_nxt = s0;
    phase_nxt   = ph0;
    unique case (ph0)
      PH_LEAD: begin
        phase_nxt = PH_TOP;
      end
      PH_TOP: begin
        phase_nxt = PH_BOTTOM;
      end
      PH_BOTTOM: begin
        phase_nxt = PH_COLS;
        col_nxt   = 7'd0;
        lower_nxt = 1'b0;
      end
      PH_COLS: begin
        if (!l0) begin
          lower_nxt = 1'b1;
        end else begin
          lower_nxt = 1'b0;
          if (col_last) phase_nxt = PH_TRAIL;
          else col_nxt = c0 + 7'd1;
        end
      end
      default: begin
        started_nxt = 1'b1;
        phase_nxt   = PH_LEAD;
        col_nxt     = 7'd0;
        lower_nxt   = 1'b0;
        if (row_last) begin
          row_nxt = 7'd0;
          if (f0 >= 3'(LAST_FACE)) begin
            face_nxt    = 3'd0;
            started_nxt = 1'b0;
          end else begin
            face_nxt = f0 + 3'd1;
          end
        end else begin
          row_nxt = r0 + 7'd1;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      subdiv_r <= 7'd1;
      step_r   <= 15'(ONE_Q);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        CFG_SUBDIV: subdiv_r <= subdiv_wr;
        default:    step_r   <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      face_r      <= 3'd0;
      row_r       <= 7'd0;
      col_r       <= 7'd0;
      phase_r     <= PH_LEAD;
      lower_r     <= 1'b0;
      started_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        face_r      <= face_nxt;
        row_r       <= row_nxt;
        col_r       <= col_nxt;
        phase_r     <= phase_nxt;
        lower_r     <= lower_nxt;
        started_r   <= started_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // result register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      pos_x_r    <= pos_x_nxt;
      pos_y_r    <= pos_y_nxt;
      pos_z_r    <= pos_z_nxt;
      norm_x_r   <= fd.norm_x;
      norm_y_r   <= fd.norm_y;
      norm_z_r   <= fd.norm_z;
      tex_u_r    <= tex_u_nxt;
      tex_v_r    <= tex_v_nxt;
      mesh_end_r <= mesh_end_nxt;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_pos_x    = pos_x_r;
  assign out_pos_y    = pos_y_r;
  assign out_pos_z    = pos_z_r;
  assign out_norm_x   = norm_x_r;
  assign out_norm_y   = norm_y_r;
  assign out_norm_z   = norm_z_r;
  assign out_tex_u    = tex_u_r;
  assign out_tex_v    = tex_v_r;
  assign out_mesh_end = mesh_end_r;

endmodule

`default_nettype wire

>>> tb/sv/tb_cube_strip_vertex_generator_top.sv
// tb_cube_strip_vertex_generator_top: self-checking bench for the cube strip vertex generator
// predicts every vertex of the strip walk in the bench and compares each output item in order
// depends on csvg_pkg and cube_strip_vertex_generator_top
`timescale 1ns / 100ps

module tb_cube_strip_vertex_generator_top;
  import csvg_pkg::*;

  localparam int FACE_XNEG = 0;
  localparam int FACE_XPOS = 1;
  localparam int FACE_YNEG = 2;
  localparam int FACE_YPOS = 3;
  localparam int FACE_ZNEG = 4;
  localparam int FACE_ZPOS = 5;
  localparam longint HALF_Q = HALF_SIDE;
  localparam longint FULL_Q = ONE_Q;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic signed [1:0]  norm_x;
    logic signed [1:0]  norm_y;
    logic signed [1:0]  norm_z;
    logic signed [15:0] tex_u;
    logic [14:0]        tex_v;
    logic               mesh_end;
  } vertex_t;

  typedef struct {
    int cx, cy, cz;
    int nx, ny, nz;
    int va, ha;
    int vs, hs;
  } geom_t;

  logic clk = 1'b0;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic in_restart;
  logic out_valid;
  logic out_stall;
  logic signed [15:0] out_pos_x;
  logic signed [15:0] out_pos_y;
  logic signed [15:0] out_pos_z;
  logic signed [1:0] out_norm_x;
  logic signed [1:0] out_norm_y;
  logic signed [1:0] out_norm_z;
  logic signed [15:0] out_tex_u;
  logic [14:0] out_tex_v;
  logic out_mesh_end;
  logic cfg_valid;
  logic cfg_ready;
  logic cfg_index;
  logic [14:0] cfg_data;

  // predicted strip walk
  int reg_subdiv;
  int reg_step;
  int walk_face;
  int walk_row;
  int walk_col;
  phase_t walk_phase;
  bit walk_lower;
  bit walk_started;

  vertex_t vertex_q[$];
  bit idle_on = 1'b1;
  bit last_end;
  int stall_left = 0;
  int err_count = 0;
  int items_sent = 0;
  int vertices_checked = 0;
  int meshes_seen = 0;
  int cfg_writes = 0;

  cube_strip_vertex_generator_top i_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_restart   (in_restart),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_pos_x    (out_pos_x),
    .out_pos_y    (out_pos_y),
    .out_pos_z    (out_pos_z),
    .out_norm_x   (out_norm_x),
    .out_norm_y   (out_norm_y),
    .out_norm_z   (out_norm_z),
    .out_tex_u    (out_tex_u),
    .out_tex_v    (out_tex_v),
    .out_mesh_end (out_mesh_end),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #6 clk = ~clk;

  function automatic int span_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(6, 20);
  endfunction

  function automatic int round_step(input int n);
    return (ONE_Q + n / 2) / n;
  endfunction

  function automatic longint clip(input longint x, input longint lo, input longint hi);
    return (x < lo) ? lo : ((x > hi) ? hi : x);
  endfunction

  function automatic geom_t face_geom(input int f);
    geom_t g;
    case (f)
      FACE_XNEG: g = '{-1,  1, -1, -1,  0,  0, 1, 2, -1,  1};
      FACE_XPOS: g = '{ 1,  1,  1,  1,  0,  0, 1, 2, -1, -1};
      FACE_YNEG: g = '{-1, -1,  1,  0, -1,  0, 2, 0, -1,  1};
      FACE_YPOS: g = '{-1,  1, -1,  0,  1,  0, 2, 0,  1,  1};
      FACE_ZNEG: g = '{ 1,  1, -1,  0,  0, -1, 1, 0, -1, -1};
      default:   g = '{-1,  1,  1,  0,  0,  1, 1, 0, -1,  1};
    endcase
    return g;
  endfunction

  function automatic void clear_walk();
    walk_face = FACE_XNEG;
    walk_row = 0;
    walk_col = 0;
    walk_phase = PH_LEAD;
    walk_lower = 1'b0;
    walk_started = 1'b0;
  endfunction

  // vertex for one advance item, then step the walk
  function automatic vertex_t next_vertex(input logic restart);
    geom_t g;
    longint p[3];
    longint stp, vofs, hofs, u, v;
    int n;
    vertex_t r;
    n = reg_subdiv;
    stp = reg_step;
    if (restart) clear_walk();
    if (walk_phase == PH_LEAD && !walk_started) walk_phase = PH_TOP;
    g = face_geom(walk_face);
    vofs = walk_row;
    hofs = 0;
    u = 0;
    v = walk_row * stp;
    case (walk_phase)
      PH_BOTTOM: begin
        vofs += 1;
        v += stp;
      end
      PH_COLS: begin
        hofs = walk_col + 1;
        u = hofs * stp * g.hs;
        if (walk_lower) begin
          vofs += 1;
          v += stp;
        end
      end
      PH_TRAIL: begin
        vofs += 1;
        hofs = n;
        u = FULL_Q;
      end
      default: ;
    endcase
    p[0] = g.cx * HALF_Q;
    p[1] = g.cy * HALF_Q;
    p[2] = g.cz * HALF_Q;
    p[g.va] += vofs * stp * g.vs;
    p[g.ha] += hofs * stp * g.hs;
    r.pos_x = 16'(clip(p[0], -FULL_Q, FULL_Q));
    r.pos_y = 16'(clip(p[1], -FULL_Q, FULL_Q));
    r.pos_z = 16'(clip(p[2], -FULL_Q, FULL_Q));
    r.norm_x = 2'(g.nx);
    r.norm_y = 2'(g.ny);
    r.norm_z = 2'(g.nz);
    r.tex_u = 16'(clip(u, -FULL_Q, FULL_Q));
    r.tex_v = 15'(clip(v, 0, FULL_Q));
    r.mesh_end = (walk_phase == PH_TRAIL) && (walk_row + 1 >= n) && (walk_face == FACE_ZPOS);
    case (walk_phase)
      PH_LEAD: walk_phase = PH_TOP;
      PH_TOP: walk_phase = PH_BOTTOM;
      PH_BOTTOM: begin
        walk_phase = PH_COLS;
        walk_col = 0;
        walk_lower = 1'b0;
      end
      PH_COLS: begin
        if (!walk_lower) begin
          walk_lower = 1'b1;
        end else begin
          walk_lower = 1'b0;
          if (walk_col + 1 >= n) walk_phase = PH_TRAIL;
          else walk_col = (walk_col + 1) & 'h7F;
        end
      end
      default: begin
        walk_started = 1'b1;
        walk_phase = PH_LEAD;
        walk_col = 0;
        walk_lower = 1'b0;
        if (walk_row + 1 >= n) begin
          walk_row = 0;
          if (walk_face >= FACE_ZPOS) clear_walk();
          else walk_face++;
        end else begin
          walk_row = (walk_row + 1) & 'h7F;
        end
      end
    endcase
    return r;
  endfunction

  task automatic send_item(input logic restart);
    int gap;
    bit hold;
    vertex_t want;
    gap = idle_on ? span_len() : 0;
    hold = idle_on && ($urandom_range(0, 39) == 0);
    if (hold && gap == 0) gap = 1;
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 1'b0;
      if (hold) while (vertex_q.size() != 0) @(negedge clk);
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_restart <= restart;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    want = next_vertex(restart);
    vertex_q.push_back(want);
    last_end = want.mesh_end;
    items_sent++;
  endtask

  task automatic drain_vertices();
    @(negedge clk) in_valid <= 1'b0;
    while (vertex_q.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [14:0] data);
    int nv;
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == CFG_SUBDIV) begin
      nv = data[6:0];
      if (nv == 0) nv = 1;
      if (nv > MAX_SUBDIV) nv = MAX_SUBDIV;
      reg_subdiv = nv;
    end else begin
      reg_step = data;
    end
    cfg_writes++;
    @(negedge clk) cfg_valid <= 1'b0;
  endtask

  // reset values: n 1, full cell step, first face then a lead on the next
  task automatic test_first_vertices();
    repeat (6) send_item(1'b0);
    drain_vertices();
  endtask

  task automatic test_restart_mid_mesh();
    send_item(1'b0);
    send_item(1'b1);
    send_item(1'b0);
    drain_vertices();
  endtask

  // clamped subdivision writes, zero and full-scale cell steps, saturation
  task automatic test_register_limits();
    write_reg(CFG_STEP, 15'h7FFF);
    write_reg(CFG_SUBDIV, 15'h7FFF);
    send_item(1'b1);
    repeat (2) send_item(1'b0);
    drain_vertices();
    write_reg(CFG_SUBDIV, 15'h0000);
    send_item(1'b1);
    repeat (2) send_item(1'b0);
    drain_vertices();
    write_reg(CFG_STEP, 15'h0000);
    write_reg(CFG_SUBDIV, 15'h0041);
    send_item(1'b0);
    drain_vertices();
    write_reg(CFG_SUBDIV, 15'h0080);
    send_item(1'b0);
    drain_vertices();
  endtask

  // row counter left beyond a smaller n
  task automatic test_shrink_mid_mesh();
    write_reg(CFG_SUBDIV, 15'd3);
    write_reg(CFG_STEP, 15'(round_step(3)));
    send_item(1'b1);
    repeat (10) send_item(1'b0);
    drain_vertices();
    write_reg(CFG_SUBDIV, 15'd1);
    repeat (4) send_item(1'b0);
    drain_vertices();
  endtask

  task automatic test_full_meshes();
    int n;
    repeat (3) begin
      n = $urandom_range(1, 2);
      write_reg(CFG_SUBDIV, 15'(n));
      write_reg(CFG_STEP, 15'(round_step(n)));
      send_item(1'b1);
      while (!last_end) send_item(1'b0);
      repeat (2) send_item(1'b0);
      drain_vertices();
    end
  endtask

  task automatic test_random_walks();
    int kind;
    int n;
    int count;
    for (int ph = 0; ph < 8; ph++) begin
      idle_on = (ph % 4 != 3);
      kind = $urandom_range(0, 9);
      if (kind < 6) n = $urandom_range(1, 6);
      else if (kind < 8) n = $urandom_range(1, MAX_SUBDIV);
      else n = MAX_SUBDIV;
      if (kind == 9) begin
        write_reg(CFG_SUBDIV, 15'($urandom_range(0, 'h7FFF)));
        write_reg(CFG_STEP, 15'($urandom_range(0, 'h7FFF)));
      end else begin
        write_reg(CFG_SUBDIV, 15'(n));
        write_reg(CFG_STEP, 15'(round_step(n)));
      end
      count = $urandom_range(15, 40);
      repeat (count) send_item($urandom_range(0, 24) == 0);
      drain_vertices();
    end
    idle_on = 1'b1;
  endtask

  always @(negedge clk) begin
    if (!idle_on) begin
      out_stall <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      stall_left = span_len();
    end
  end

  always @(posedge clk) begin : check_vertex
    vertex_t got;
    vertex_t want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_pos_x, out_pos_y, out_pos_z, out_norm_x, out_norm_y, out_norm_z,
              out_tex_u, out_tex_v, out_mesh_end};
      if (vertex_q.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("unexpected vertex pos %0d %0d %0d", got.pos_x, got.pos_y, got.pos_z);
      end else begin
        want = vertex_q.pop_front();
        vertices_checked++;
        if (got.mesh_end) meshes_seen++;
        if (got !== want) begin
          err_count++;
          if (err_count <= 10) begin
            $display("vertex %0d expected pos %0d %0d %0d norm %0d %0d %0d uv %0d %0d end %0b",
                     vertices_checked, want.pos_x, want.pos_y, want.pos_z, want.norm_x,
                     want.norm_y, want.norm_z, want.tex_u, want.tex_v, want.mesh_end);
            $display("  actual pos %0d %0d %0d norm %0d %0d %0d uv %0d %0d end %0b",
                     got.pos_x, got.pos_y, got.pos_z, got.norm_x, got.norm_y, got.norm_z,
                     got.tex_u, got.tex_v, got.mesh_end);
          end
        end
      end
    end
  end

  initial begin
    #5_000_000;
    $display("cube_strip_vertex_generator_top: mismatch");
    $finish;
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_restart = 1'b0;
    out_stall = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = CFG_SUBDIV;
    cfg_data = '0;
    reg_subdiv = 1;
    reg_step = ONE_Q;
    clear_walk();
    repeat (11) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    @(posedge clk);
    test_first_vertices();
    test_restart_mid_mesh();
    test_register_limits();
    test_shrink_mid_mesh();
    test_full_meshes();
    test_random_walks();
    drain_vertices();
    $display("sent %0d advance items, checked %0d vertices, %0d mesh ends, %0d register writes",
             items_sent, vertices_checked, meshes_seen, cfg_writes);
    $display("walks covered restarts, clamped subdivisions, saturated coordinates and wraps");
    if (err_count == 0) begin
      $display("cube_strip_vertex_generator_top: match");
    end else begin
      $display("%0d mismatches", err_count);
      $display("cube_strip_vertex_generator_top: mismatch");
    end
    $finish;
  end

endmodule
